// ===== hdl/mtim_pkg.sv =====
package mtim_pkg;

  localparam logic [31:0] NONE_S    = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_ADD_S = 32'd429496728;
  localparam logic [47:0] T48       = 48'hFFFF_FFFF_FFFF;
  // ceil(2^38 / 1000); exact quotient for any 32-bit dividend
  localparam logic [28:0] RECIP_1000 = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;

  localparam logic CFG_POLL_MODE     = 1'b0;
  localparam logic CFG_POLL_INTERVAL = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_ACT    = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_IDLE   = 2'd1,
    KIND_ACTIVE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_ARG   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_RM_SCAN,
    S_ACT,
    S_SCAN_A,
    S_CHK_PRE,
    S_CHK_CUR,
    S_CHK_CMP,
    S_SCAN_C,
    S_DIV1,
    S_DIV2,
    S_RC1,
    S_RC2,
    S_RC3,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    R_EMIT,
    R_ACT,
    R_CHK
  } ret_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  observer_id;
    logic [31:0] threshold_s;
    logic [31:0] idle_ms;
    logic [47:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  notify_id;
    logic [22:0] idle_seconds;
    logic [1:0]  status;
    logic [47:0] deadline_ms;
    logic        deadline_set;
    logic        last;
  } out_item_t;

  // classified item handed from the front end to the engine
  typedef struct packed {
    op_t         op;
    logic        add_bad;
    logic        rm_bad;
    logic [7:0]  id;
    logic [31:0] thr;
    logic [31:0] idle_ms;
    logic [47:0] now_ms;
  } cmd_t;

endpackage

// ===== hdl/mtim_front.sv =====
module mtim_front
  import mtim_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.op      = op_t'(in_item.func);
    cls.add_bad = (in_item.threshold_s == 32'd0) || (in_item.threshold_s > MAX_ADD_S);
    cls.rm_bad  = (in_item.threshold_s == 32'd0);
    cls.id      = in_item.observer_id;
    cls.thr     = in_item.threshold_s;
    cls.idle_ms = in_item.idle_ms;
    cls.now_ms  = in_item.now_ms;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = ent[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/mtim_engine.sv =====
module mtim_engine
  import mtim_pkg::*;
#(
  parameter int MAX_LISTENERS = 16,
  parameter int GUARD_MS      = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic        poll_mode,
  input  logic [15:0] poll_interval_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  localparam int CW = $clog2(MAX_LISTENERS + 1);
  localparam int IW = (MAX_LISTENERS > 1) ? $clog2(MAX_LISTENERS) : 1;

  state_t state, state_next;
  ret_t   ret;

  op_t         op;
  logic [7:0]  id_r;
  logic [31:0] thr_r;
  logic [31:0] idle_r;
  logic [47:0] now_r;
  logic        add_bad;
  logic        rm_bad;
  status_t     status_r;

  logic [7:0]  ids  [MAX_LISTENERS];
  logic [28:0] thrs [MAX_LISTENERS];
  logic        idl  [MAX_LISTENERS];
  logic [CW-1:0] count;

  logic [31:0] ns;
  logic        any_idle;
  logic [47:0] last_int;
  logic [47:0] dl;

  logic [CW-1:0] i;
  logic [7:0]    woke  [MAX_LISTENERS];
  logic [7:0]    slept [MAX_LISTENERS];
  logic [CW-1:0] wcnt;
  logic [CW-1:0] scnt;

  logic [31:0] since;
  logic [31:0] x_r;
  logic [60:0] dprod;
  logic [22:0] secs;
  logic [41:0] rc_prod;
  logic [48:0] rc_next;
  logic [48:0] rc_cap;

  logic          out_free;
  logic          scan_done;
  logic [IW-1:0] ix;
  logic [7:0]    cur_id;
  logic [28:0]   cur_thr;
  logic          cur_idle;
  logic [31:0]   cur_c;
  logic [47:0]   diff;
  logic          rc_skip;
  state_t        ret_state;
  logic [48:0]   nxt;
  logic [48:0]   tbase;
  logic [49:0]   tsum;
  logic [CW-1:0] wtop;
  logic [CW-1:0] stop;

  assign out_free  = !out_valid || out_ready;
  assign scan_done = (i == count);
  assign ix        = i[IW-1:0];
  assign cur_id    = ids[ix];
  assign cur_thr   = thrs[ix];
  assign cur_idle  = idl[ix];
  assign cmd_ready = (state == S_IDLE);
  assign diff      = (cmd.now_ms > last_int) ? cmd.now_ms - last_int : 48'd0;
  assign cur_c     = (poll_mode && idle_r < since) ? idle_r : since;
  assign rc_skip   = !any_idle && (ns == NONE_S);
  assign nxt       = (any_idle && poll_mode && rc_next > rc_cap) ? rc_cap : rc_next;
  assign tbase     = (nxt > {1'b0, now_r}) ? nxt : {1'b0, now_r};
  assign tsum      = {1'b0, tbase} + 50'(GUARD_MS);
  assign wtop      = wcnt - CW'(1);
  assign stop      = scnt - CW'(1);

  always_comb begin
    case (ret)
      R_ACT:   ret_state = S_DIV1;
      default: ret_state = S_EMIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_ADD:    state_next = S_ADD;
            OP_REMOVE: state_next = S_RM_SCAN;
            OP_ACT:    state_next = S_ACT;
            default:   state_next = S_CHK_PRE;
          endcase
        end
      end
      S_ADD: begin
        if (add_bad || count >= CW'(MAX_LISTENERS)) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_RC1;
        end
      end
      S_RM_SCAN: begin
        if (rm_bad || scan_done ||
            (cur_id == id_r && {3'b0, cur_thr} == thr_r)) begin
          state_next = S_EMIT;
        end
      end
      S_ACT: state_next = any_idle ? S_SCAN_A : S_EMIT;
      S_SCAN_A: begin
        if (scan_done) begin
          state_next = S_RC1;
        end
      end
      S_CHK_PRE: state_next = S_CHK_CUR;
      S_CHK_CUR: begin
        if (since > cur_c && any_idle) begin
          state_next = S_SCAN_A;
        end else begin
          state_next = S_DIV1;
        end
      end
      S_CHK_CMP: state_next = (ns > {9'b0, secs}) ? S_RC1 : S_SCAN_C;
      S_SCAN_C: begin
        if (scan_done) begin
          state_next = S_RC1;
        end
      end
      S_DIV1: state_next = S_DIV2;
      S_DIV2: state_next = (op == OP_CHECK) ? S_CHK_CMP : S_EMIT;
      S_RC1:  state_next = rc_skip ? ret_state : S_RC2;
      S_RC2:  state_next = S_RC3;
      S_RC3:  state_next = ret_state;
      S_EMIT: begin
        if (out_free && wcnt == '0 && scnt == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // table and scratch payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op      <= cmd.op;
        id_r    <= cmd.id;
        thr_r   <= cmd.thr;
        idle_r  <= cmd.idle_ms;
        now_r   <= cmd.now_ms;
        add_bad <= cmd.add_bad;
        rm_bad  <= cmd.rm_bad;
        since   <= (diff > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : diff[31:0];
      end
      S_ADD: begin
        if (!add_bad && count < CW'(MAX_LISTENERS)) begin
          ids[count[IW-1:0]]  <= id_r;
          thrs[count[IW-1:0]] <= thr_r[28:0];
          idl[count[IW-1:0]]  <= 1'b0;
        end
      end
      S_RM_SCAN: begin
        if (!rm_bad && !scan_done && cur_id == id_r && {3'b0, cur_thr} == thr_r) begin
          for (int k = 0; k < MAX_LISTENERS - 1; k++) begin
            if (CW'(k) >= i) begin
              ids[k]  <= ids[k+1];
              thrs[k] <= thrs[k+1];
              idl[k]  <= idl[k+1];
            end
          end
        end
      end
      S_ACT: x_r <= idle_r;
      S_SCAN_A: begin
        if (!scan_done && cur_idle) begin
          woke[wcnt[IW-1:0]] <= cur_id;
          idl[ix]            <= 1'b0;
        end
      end
      S_CHK_CUR: x_r <= cur_c;
      S_SCAN_C: begin
        if (!scan_done && !cur_idle && {3'b0, cur_thr} <= {9'b0, secs}) begin
          slept[scnt[IW-1:0]] <= cur_id;
          idl[ix]             <= 1'b1;
        end
      end
      S_DIV1: dprod <= {29'b0, x_r} * {32'b0, RECIP_1000};
      S_DIV2: secs  <= dprod[60:RECIP_SHIFT];
      S_RC1:  rc_prod <= ({10'b0, ns} << 10) - ({10'b0, ns} << 4) - ({10'b0, ns} << 3);
      S_RC2: begin
        rc_next <= {1'b0, last_int} + {7'b0, rc_prod};
        rc_cap  <= {1'b0, now_r} + {33'b0, poll_interval_ms};
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ns        <= NONE_S;
      any_idle  <= 1'b0;
      last_int  <= 48'd0;
      dl        <= 48'd0;
      i         <= '0;
      wcnt      <= '0;
      scnt      <= '0;
      ret       <= R_EMIT;
      status_r  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          i        <= '0;
          wcnt     <= '0;
          scnt     <= '0;
          status_r <= ST_OK;
          ret      <= R_EMIT;
        end
        S_ADD: begin
          if (add_bad) begin
            status_r <= ST_BAD_ARG;
          end else if (count >= CW'(MAX_LISTENERS)) begin
            status_r <= ST_FULL;
          end else begin
            count <= count + CW'(1);
            if (ns > thr_r) begin
              ns <= thr_r;
            end
          end
        end
        S_RM_SCAN: begin
          if (rm_bad) begin
            status_r <= ST_BAD_ARG;
          end else if (scan_done) begin
            status_r <= ST_NOT_FOUND;
          end else if (cur_id == id_r && {3'b0, cur_thr} == thr_r) begin
            count <= count - CW'(1);
          end else begin
            i <= i + CW'(1);
          end
        end
        S_ACT: begin
          last_int <= (now_r >= {16'b0, idle_r}) ? now_r - {16'b0, idle_r} : 48'd0;
          if (any_idle) begin
            ns <= NONE_S;
          end
        end
        S_SCAN_A: begin
          if (scan_done) begin
            any_idle <= 1'b0;
            ret      <= R_ACT;
          end else begin
            if (cur_idle) begin
              wcnt <= wcnt + CW'(1);
            end
            if ({3'b0, cur_thr} < ns) begin
              ns <= {3'b0, cur_thr};
            end
            i <= i + CW'(1);
          end
        end
        S_CHK_PRE: dl <= 48'd0;
        S_CHK_CUR: begin
          if (since > cur_c) begin
            last_int <= (now_r >= {16'b0, cur_c}) ? now_r - {16'b0, cur_c} : 48'd0;
            if (any_idle) begin
              ns <= NONE_S;
            end
          end
        end
        S_CHK_CMP: begin
          i   <= '0;
          ret <= R_EMIT;
          if (!(ns > {9'b0, secs})) begin
            ns <= NONE_S;
          end
        end
        S_SCAN_C: begin
          if (scan_done) begin
            ret <= R_CHK;
          end else begin
            i <= i + CW'(1);
            if (!cur_idle) begin
              if ({3'b0, cur_thr} <= {9'b0, secs}) begin
                scnt <= scnt + CW'(1);
              end else if ({3'b0, cur_thr} < ns) begin
                ns <= {3'b0, cur_thr};
              end
            end
          end
        end
        S_RC1: begin
          if (rc_skip && ret == R_CHK && scnt != '0) begin
            any_idle <= 1'b1;
          end
        end
        S_RC3: begin
          if (dl == 48'd0 || {1'b0, dl} > nxt) begin
            dl <= (tsum > {2'b0, T48}) ? T48 : tsum[47:0];
          end
          if (ret == R_CHK && scnt != '0) begin
            any_idle <= 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_item.deadline_ms  <= dl;
            out_item.deadline_set <= (dl != 48'd0);
            if (wcnt != '0) begin
              out_item.kind         <= KIND_ACTIVE;
              out_item.notify_id    <= woke[wtop[IW-1:0]];
              out_item.idle_seconds <= secs;
              out_item.status       <= ST_OK;
              out_item.last         <= 1'b0;
              wcnt                  <= wtop;
            end else if (scnt != '0) begin
              out_item.kind         <= KIND_IDLE;
              out_item.notify_id    <= slept[stop[IW-1:0]];
              out_item.idle_seconds <= secs;
              out_item.status       <= ST_OK;
              out_item.last         <= 1'b0;
              scnt                  <= stop;
            end else begin
              out_item.kind         <= KIND_STATUS;
              out_item.notify_id    <= 8'd0;
              out_item.idle_seconds <= 23'd0;
              out_item.status       <= status_r;
              out_item.last         <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/multi_threshold_idle_monitor_top.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------
// in       | in_valid / in_ready    | in_item  (func, id, thr, idle, now)
// out      | out_valid / out_ready  | out_item (notice or status, last)
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// After the engine takes an item it runs add, remove, activity or check;
// the table scans go one entry per cycle, and the notices leave serially,
// each as its own result, ahead of the closing status result.
// A 2-deep command queue accepts items while the engine works, until full;
// the output register holds a result until it is taken, stalling the engine.
// Synchronous reset; the input is ready in the first cycle after reset.
module multi_threshold_idle_monitor_top
  import mtim_pkg::*;
#(
  parameter int MAX_LISTENERS = 16,
  parameter int GUARD_MS      = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        cmd_valid;
  logic        cmd_ready;
  cmd_t        cmd;
  logic        poll_mode;
  logic [15:0] poll_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_mode        <= 1'b0;
      poll_interval_ms <= 16'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLL_MODE:     poll_mode        <= cfg_data[0];
        CFG_POLL_INTERVAL: poll_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mtim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mtim_engine #(
    .MAX_LISTENERS (MAX_LISTENERS),
    .GUARD_MS      (GUARD_MS)
  ) u_engine (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .poll_mode        (poll_mode),
    .poll_interval_ms (poll_interval_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item)
  );

endmodule

// ===== hdl/mtim_checker.sv =====
module mtim_checker
  import mtim_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.last == (out_item.kind == KIND_STATUS)))
    else $error("last flag does not mark the status result");

  a_notice_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_STATUS |-> out_item.status == ST_OK)
    else $error("notice carries a status code");

  a_deadline_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.deadline_set == (out_item.deadline_ms != 48'd0))
    else $error("deadline flag inconsistent");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_STATUS |->
      out_item.notify_id == 8'd0 && out_item.idle_seconds == 23'd0)
    else $error("status result carries notice fields");

endmodule

bind multi_threshold_idle_monitor_top mtim_checker u_checker (.*);
